### rtl/core/obm_pkg.sv
// Shared types, constants and register map of the outer border marker.
package obm_pkg;

	localparam int PIX_W         = 24;
	localparam int EW_W          = 15;
	localparam int ROW_W         = 14;
	localparam int OY_W          = 13;
	localparam int ADDR_W        = 4;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT    = 8192;

	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_TRIGGER = 2'd2;
	localparam logic [1:0] REG_BORDER  = 2'd3;

	localparam logic [12:0]      WIDTH_RST   = 13'd640;
	localparam logic [13:0]      HEIGHT_RST  = 14'd480;
	localparam logic [PIX_W-1:0] TRIGGER_RST = 24'h000000;
	localparam logic [PIX_W-1:0] BORDER_RST  = 24'hFFFFFF;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic             restart;
		logic [EW_W-1:0]  width;
		logic [ROW_W-1:0] height;
		logic [PIX_W-1:0] trigger;
		logic [PIX_W-1:0] border;
	} cfg_t;

endpackage

### rtl/core/obm_cfg.sv
// Configuration registers with APB access and effective frame geometry.
module obm_cfg #(
	parameter int MAX_WIDTH = obm_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [obm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output obm_pkg::cfg_t              cfg
);

	logic [12:0]               width_q;
	logic [13:0]               height_q;
	logic [obm_pkg::PIX_W-1:0] trigger_q;
	logic [obm_pkg::PIX_W-1:0] border_q;
	logic                      wr;
	logic [1:0]                idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= obm_pkg::WIDTH_RST;
			height_q  <= obm_pkg::HEIGHT_RST;
			trigger_q <= obm_pkg::TRIGGER_RST;
			border_q  <= obm_pkg::BORDER_RST;
		end else if (wr) begin
			case (idx)
				obm_pkg::REG_WIDTH:   width_q   <= pwdata[12:0];
				obm_pkg::REG_HEIGHT:  height_q  <= pwdata[13:0];
				obm_pkg::REG_TRIGGER: trigger_q <= pwdata[obm_pkg::PIX_W-1:0];
				obm_pkg::REG_BORDER:  border_q  <= pwdata[obm_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			obm_pkg::REG_WIDTH:   prdata = 32'(width_q);
			obm_pkg::REG_HEIGHT:  prdata = 32'(height_q);
			obm_pkg::REG_TRIGGER: prdata = 32'(trigger_q);
			obm_pkg::REG_BORDER:  prdata = 32'(border_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		cfg.restart = wr && (idx == obm_pkg::REG_WIDTH || idx == obm_pkg::REG_HEIGHT);
		if (width_q == '0) begin
			cfg.width = obm_pkg::EW_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			cfg.width = obm_pkg::EW_W'(MAX_WIDTH);
		end else begin
			cfg.width = obm_pkg::EW_W'(width_q);
		end
		if (height_q == '0) begin
			cfg.height = obm_pkg::ROW_W'(1);
		end else if (32'(height_q) > 32'(obm_pkg::MAX_HEIGHT)) begin
			cfg.height = obm_pkg::ROW_W'(obm_pkg::MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
		cfg.trigger = trigger_q;
		cfg.border  = border_q;
	end

endmodule

### rtl/core/obm_line_store.sv
// Two-row line store: one entry per column holding the center and above rows.
module obm_line_store #(
	parameter int DEPTH  = obm_pkg::MAX_WIDTH_DEF,
	parameter int DATA_W = 2 * obm_pkg::PIX_W
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

endmodule

### rtl/core/obm_window.sv
// 3x3 window, output position tracking and border decision.
module obm_window #(
	parameter int MAX_WIDTH = obm_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  obm_pkg::cfg_t             cfg,
	input  logic                      adv,
	input  logic                      emit,
	input  logic [obm_pkg::PIX_W-1:0] above,
	input  logic [obm_pkg::PIX_W-1:0] mid,
	input  logic [obm_pkg::PIX_W-1:0] pix,
	output logic [obm_pkg::PIX_W-1:0] pixel,
	output logic                      last
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [obm_pkg::PIX_W-1:0] win_q [3][3];
	logic [obm_pkg::PIX_W-1:0] nw [3][3];
	logic [CW-1:0]             ox_q;
	logic [obm_pkg::OY_W-1:0]  oy_q;
	logic                      top_ok, bot_ok, left_ok, right_ok;
	logic                      right_edge, bot_edge;
	logic                      hit;
	logic [obm_pkg::PIX_W-1:0] center, t;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i][0] = win_q[i][1];
			nw[i][1] = win_q[i][2];
		end
		nw[0][2] = above;
		nw[1][2] = mid;
		nw[2][2] = pix;
	end

	assign t          = cfg.trigger;
	assign center     = nw[1][1];
	assign right_edge = (obm_pkg::EW_W'(ox_q) == cfg.width - obm_pkg::EW_W'(1));
	assign bot_edge   = (obm_pkg::ROW_W'(oy_q) == cfg.height - obm_pkg::ROW_W'(1));
	assign top_ok     = (oy_q != '0);
	assign bot_ok     = !bot_edge;
	assign left_ok    = (ox_q != '0);
	assign right_ok   = !right_edge;
	assign last       = right_edge && bot_edge;

	assign hit = (top_ok && left_ok  && nw[0][0] == t) ||
	             (top_ok             && nw[0][1] == t) ||
	             (top_ok && right_ok && nw[0][2] == t) ||
	             (left_ok            && nw[1][0] == t) ||
	             (right_ok           && nw[1][2] == t) ||
	             (bot_ok && left_ok  && nw[2][0] == t) ||
	             (bot_ok             && nw[2][1] == t) ||
	             (bot_ok && right_ok && nw[2][2] == t);

	assign pixel = (hit && center != t) ? cfg.border : center;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
			ox_q <= '0;
			oy_q <= '0;
		end else begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						win_q[i][j] <= nw[i][j];
					end
				end
			end
			if (cfg.restart) begin
				ox_q <= '0;
				oy_q <= '0;
			end else if (adv && emit) begin
				if (last) begin
					ox_q <= '0;
					oy_q <= '0;
				end else if (right_edge) begin
					ox_q <= '0;
					oy_q <= oy_q + 1'b1;
				end else begin
					ox_q <= ox_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/outer_border_marker.sv
// Outer border marker top level: input slot counters, pipeline control, output register.
// Output: the result for a pixel is released by the item w+1 positions later; it is
// registered in stage s1 and then in the output register before it appears on m_tvalid.
// Throughput: one item per cycle unless the output stalls; line store read on load, written on s1_adv.
// Reset: counters, window and handshake state clear; line store contents stay unknown.
module outer_border_marker #(
	parameter int MAX_WIDTH = obm_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [obm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [obm_pkg::PIX_W-1:0]  s_tdata,   // pixel_in
	input  logic                       s_tuser,   // op
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [obm_pkg::PIX_W-1:0]  m_tdata,   // pixel_out
	output logic                       m_tlast
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = obm_pkg::PIX_W;

	obm_pkg::cfg_t             cfg;
	logic [CW-1:0]             col_q;
	logic [obm_pkg::ROW_W-1:0] row_q;
	logic                      accept, ignore, load, in_frame;
	logic                      col_end, frame_done, emit_in;
	logic [PW-1:0]             pix_in;

	logic                      s1_valid_s1, s1_emit_s1, s1_last_s1;
	logic [PW-1:0]             s1_pix_s1;
	logic [CW-1:0]             s1_addr_s1;
	logic                      s1_adv, out_free;

	logic [2*PW-1:0]           rd_data;
	logic [PW-1:0]             win_pixel;
	logic                      win_last;

	logic                      out_valid_q, out_last_q;
	logic [PW-1:0]             out_pixel_q;

	obm_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_frame   = (row_q < cfg.height);
	assign accept     = s_tvalid && s_tready;
	assign ignore     = in_frame && (s_tuser == obm_pkg::OP_DRAIN);
	assign load       = accept && !ignore;
	assign col_end    = (obm_pkg::EW_W'(col_q) == cfg.width - obm_pkg::EW_W'(1));
	assign frame_done = (obm_pkg::EW_W'(row_q) == obm_pkg::EW_W'(cfg.height) + obm_pkg::EW_W'(1))
	                    && (col_q == '0);
	assign emit_in    = (row_q >= obm_pkg::ROW_W'(2)) ||
	                    (row_q == obm_pkg::ROW_W'(1) && col_q != '0);
	assign pix_in     = in_frame ? s_tdata : '0;

	assign out_free = !out_valid_q || m_tready;
	assign s1_adv   = s1_valid_s1 && (!s1_emit_s1 || out_free);
	assign s_tready = !s1_valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (load) begin
			if (frame_done) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (load) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			s1_emit_s1 <= emit_in;
			s1_last_s1 <= frame_done;
			s1_pix_s1  <= pix_in;
			s1_addr_s1 <= col_q;
		end
	end

	obm_line_store #(.DEPTH(MAX_WIDTH), .DATA_W(2 * PW)) u_lines (
		.clk     (clk),
		.rd_en   (load),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (s1_adv),
		.wr_addr (s1_addr_s1),
		.wr_data ({s1_pix_s1, rd_data[2*PW-1:PW]})
	);

	obm_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (s1_adv),
		.emit   (s1_emit_s1),
		.above  (rd_data[PW-1:0]),
		.mid    (rd_data[2*PW-1:PW]),
		.pix    (s1_pix_s1),
		.pixel  (win_pixel),
		.last   (win_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_emit_s1) begin
			out_pixel_q <= win_pixel;
			out_last_q  <= s1_last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pixel_q;
	assign m_tlast  = out_last_q;

	a_last_agrees: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && s1_emit_s1 |-> (s1_last_s1 == win_last))
		else $error("input-side frame end disagrees with output position");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && s1_last_s1 |-> s1_emit_s1)
		else $error("frame end on a slot that emits nothing");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		obm_pkg::EW_W'(row_q) <= obm_pkg::EW_W'(cfg.height) + obm_pkg::EW_W'(1))
		else $error("row counter past drain range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !s1_adv |=> s1_valid_s1)
		else $error("stalled stage lost its item");

endmodule
